// File: rtl/vpw_pkg.sv
`default_nettype none

package vpw_pkg;

  // number formats
  localparam int COORD_WIDTH = 32;
  localparam int SAT_BITS    = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_BITS   = 64 - FRAC_BITS;
  // quotient bits resolved by the divider, one per stage
  localparam int DIV_STEPS   = SAT_BITS - 1;

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
  localparam logic signed [32:0] Q_ONE  = 33'sd65536;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_PROJECT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_VP_LEFT   = 2'd0,
    REG_VP_BOTTOM = 2'd1,
    REG_VP_WIDTH  = 2'd2,
    REG_VP_HEIGHT = 2'd3
  } cfg_reg_t;

  // one finished result
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               ok;
  } win_t;

  // clamp a wide value to the signed coordinate range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[31:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // sign-extend a floored product term
  function automatic logic signed [63:0] ext_prod(input logic signed [PROD_BITS-1:0] p);
    return {{FRAC_BITS{p[PROD_BITS-1]}}, p};
  endfunction

endpackage

`default_nettype wire

// File: rtl/vertex_project_to_window_unit.sv
// Object-space to window-space point projection, signed Q16.16.
//
// Input channel (in_valid / in_ready) carries one transaction per item.
// command load writes one matrix coefficient (coef_index 0-15 model-view,
// 16-31 projection, column-major) and gives no result; command project
// transforms point_x/y/z through both matrices, divides by clip w and maps
// through the viewport, giving one result on the output channel
// (out_valid / out_ready). point_ok low means clip w was zero; the window
// fields are then zero.
// The configuration channel (cfg_valid / cfg_ready, always ready) writes
// the viewport registers; write it only while the block is idle.
// Pipeline: after its input transaction a project result passes through,
// one register stage each: two multiply/sum pairs (four stages), the divider
// set-up, a 31-stage restoring divider (one quotient bit per stage, three
// lanes sharing the divisor), the ndc stage, the viewport multiply and the
// output register. Throughput: one item per cycle while the skid register is empty.
// Reset clears both matrices, the viewport registers and all valid bits.
// When the receiver stalls, a skid register takes one more result; the
// whole pipeline then holds and in_ready drops until the skid drains.
`default_nettype none

module vertex_project_to_window_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               command,
  input  wire logic [4:0]         coef_index,
  input  wire logic signed [31:0] coef_value,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      window_x,
  output logic signed [31:0]      window_y,
  output logic signed [31:0]      window_depth,
  output logic                    point_ok,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_value
);

  localparam int PB = vpw_pkg::PROD_BITS;
  localparam int NS = vpw_pkg::DIV_STEPS;
  localparam int FB = vpw_pkg::FRAC_BITS;

  // configuration and matrix state
  logic signed [15:0] vp_left;
  logic signed [15:0] vp_bottom;
  logic [15:0]        vp_width;
  logic [15:0]        vp_height;
  logic signed [31:0] mv [16];
  logic signed [31:0] pm [16];

  logic en;
  logic in_acc;

  // stage 1: model-view products
  logic                s1_valid;
  logic                s1_cmd;
  logic [4:0]          s1_idx;
  logic signed [31:0]  s1_val;
  logic signed [PB-1:0] s1_prod [4][3];
  logic signed [31:0]  s1_trans [4];
  logic signed [PB-1:0] s1_prod_next [4][3];

  // stage 2: eye coordinates
  logic                s2_valid;
  logic                s2_cmd;
  logic [4:0]          s2_idx;
  logic signed [31:0]  s2_val;
  logic signed [31:0]  s2_eye [4];
  logic signed [31:0]  s2_eye_next [4];

  // stage 3: projection products
  logic                s3_valid;
  logic signed [PB-1:0] s3_prod [4][4];
  logic signed [PB-1:0] s3_prod_next [4][4];

  // stage 4: clip coordinates
  logic                s4_valid;
  logic signed [31:0]  s4_clip [4];
  logic signed [31:0]  s4_clip_next [4];

  // divider stages, index 0 is the set-up stage
  logic          dv_valid [NS+1];
  logic          dv_ok    [NS+1];
  logic [31:0]   dv_den   [NS+1];
  logic [31:0]   dv_rem   [NS+1][3];
  logic [NS-1:0] dv_low   [NS+1][3];
  logic [NS-1:0] dv_quo   [NS+1][3];
  logic          dv_neg   [NS+1][3];
  logic          dv_ovf   [NS+1][3];
  logic [31:0]   dv_rem_next [NS+1][3];
  logic [NS-1:0] dv_low_next [NS+1][3];
  logic [NS-1:0] dv_quo_next [NS+1][3];
  logic          dv_ovf_next [3];
  logic          dv_neg_next [3];
  logic [31:0]   dv_den_next;

  // ndc and viewport stages
  logic               nd_valid;
  logic               nd_ok;
  logic signed [31:0] nd_val [3];
  logic signed [31:0] nd_val_next [3];
  logic               vp_valid;
  logic               vp_ok;
  logic signed [49:0] vp_prod_x;
  logic signed [49:0] vp_prod_y;
  logic signed [31:0] vp_depth;
  logic signed [32:0] vp_ax;
  logic signed [32:0] vp_ay;
  logic signed [32:0] vp_az;

  // output register and skid
  vpw_pkg::win_t res;
  vpw_pkg::win_t skid;
  logic          skid_valid;

  assign en        = !skid_valid;
  assign in_ready  = en;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // viewport register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vp_left   <= '0;
      vp_bottom <= '0;
      vp_width  <= '0;
      vp_height <= '0;
    end else if (cfg_valid) begin
      unique case (vpw_pkg::cfg_reg_t'(cfg_index))
        vpw_pkg::REG_VP_LEFT:   vp_left   <= cfg_value;
        vpw_pkg::REG_VP_BOTTOM: vp_bottom <= cfg_value;
        vpw_pkg::REG_VP_WIDTH:  vp_width  <= cfg_value;
        vpw_pkg::REG_VP_HEIGHT: vp_height <= cfg_value;
        default: ;
      endcase
    end
  end

  // model-view is written as the load is taken, projection when the load
  // reaches the stage that reads it, so earlier points see the old values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mv[i] <= '0;
        pm[i] <= '0;
      end
    end else begin
      if (in_acc && command == vpw_pkg::CMD_LOAD && !coef_index[4]) begin
        mv[coef_index[3:0]] <= coef_value;
      end
      if (en && s2_valid && s2_cmd == vpw_pkg::CMD_LOAD && s2_idx[4]) begin
        pm[s2_idx[3:0]] <= s2_val;
      end
    end
  end

  // model-view products, floored to Q16.16
  always_comb begin
    logic signed [63:0] full;
    logic signed [31:0] obj [3];
    obj[0] = point_x;
    obj[1] = point_y;
    obj[2] = point_z;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        full = mv[c*4+r] * obj[c];
        s1_prod_next[r][c] = full[63:FB];
      end
    end
  end

  // eye sums
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      s2_eye_next[r] = vpw_pkg::sat32(vpw_pkg::ext_prod(s1_prod[r][0])
                                      + vpw_pkg::ext_prod(s1_prod[r][1])
                                      + vpw_pkg::ext_prod(s1_prod[r][2])
                                      + {{32{s1_trans[r][31]}}, s1_trans[r]});
    end
  end

  // projection products
  always_comb begin
    logic signed [63:0] full;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        full = pm[c*4+r] * s2_eye[c];
        s3_prod_next[r][c] = full[63:FB];
      end
    end
  end

  // clip sums
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      s4_clip_next[r] = vpw_pkg::sat32(vpw_pkg::ext_prod(s3_prod[r][0])
                                       + vpw_pkg::ext_prod(s3_prod[r][1])
                                       + vpw_pkg::ext_prod(s3_prod[r][2])
                                       + vpw_pkg::ext_prod(s3_prod[r][3]));
    end
  end

  // divider set-up: magnitudes, early overflow test, first partial remainder
  always_comb begin
    logic [31:0] mag_c;
    logic [47:0] num;
    logic [47:0] hi;
    logic [32:0] t;
    logic        ge;
    dv_den_next = s4_clip[3][31] ? 32'(-s4_clip[3]) : 32'(s4_clip[3]);
    for (int l = 0; l < 3; l++) begin
      mag_c = s4_clip[l][31] ? 32'(-s4_clip[l]) : 32'(s4_clip[l]);
      num   = {mag_c, {FB{1'b0}}};
      hi    = num >> NS;
      dv_ovf_next[l]    = hi >= {16'd0, dv_den_next};
      dv_neg_next[l]    = s4_clip[l][31] ^ s4_clip[3][31];
      dv_rem_next[0][l] = hi[31:0];
      dv_low_next[0][l] = num[NS-1:0];
      dv_quo_next[0][l] = '0;
    end
    // one restoring step per stage
    for (int k = 1; k <= NS; k++) begin
      for (int l = 0; l < 3; l++) begin
        t  = {dv_rem[k-1][l], dv_low[k-1][l][NS-1]};
        ge = t >= {1'b0, dv_den[k-1]};
        dv_rem_next[k][l] = ge ? 32'(t - {1'b0, dv_den[k-1]}) : t[31:0];
        dv_low_next[k][l] = dv_low[k-1][l] << 1;
        dv_quo_next[k][l] = {dv_quo[k-1][l][NS-2:0], ge};
      end
    end
  end

  // signed, saturated ndc
  always_comb begin
    logic [31:0] q;
    for (int l = 0; l < 3; l++) begin
      q = {{(32-NS){1'b0}}, dv_quo[NS][l]};
      if (dv_ovf[NS][l]) begin
        nd_val_next[l] = dv_neg[NS][l] ? vpw_pkg::SAT_LO[31:0] : vpw_pkg::SAT_HI[31:0];
      end else begin
        nd_val_next[l] = dv_neg[NS][l] ? -q : q;
      end
    end
  end

  // viewport scale inputs
  assign vp_ax = {nd_val[0][31], nd_val[0]} + vpw_pkg::Q_ONE;
  assign vp_ay = {nd_val[1][31], nd_val[1]} + vpw_pkg::Q_ONE;
  assign vp_az = {nd_val[2][31], nd_val[2]} + vpw_pkg::Q_ONE;

  // viewport offset and final clamp
  always_comb begin
    logic signed [63:0] sx;
    logic signed [63:0] sy;
    sx = {{15{vp_prod_x[49]}}, vp_prod_x[49:1]}
         + {{32{vp_left[15]}}, vp_left, {FB{1'b0}}};
    sy = {{15{vp_prod_y[49]}}, vp_prod_y[49:1]}
         + {{32{vp_bottom[15]}}, vp_bottom, {FB{1'b0}}};
    res.ok = vp_ok;
    res.x  = vp_ok ? vpw_pkg::sat32(sx) : '0;
    res.y  = vp_ok ? vpw_pkg::sat32(sy) : '0;
    res.z  = vp_ok ? vp_depth : '0;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      for (int k = 0; k <= NS; k++) begin
        dv_valid[k] <= 1'b0;
      end
      nd_valid <= 1'b0;
      vp_valid <= 1'b0;
    end else if (en) begin
      s1_valid    <= in_acc;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid && s2_cmd == vpw_pkg::CMD_PROJECT;
      s4_valid    <= s3_valid;
      dv_valid[0] <= s4_valid;
      for (int k = 1; k <= NS; k++) begin
        dv_valid[k] <= dv_valid[k-1];
      end
      nd_valid <= dv_valid[NS];
      vp_valid <= nd_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd <= command;
      s1_idx <= coef_index;
      s1_val <= coef_value;
      for (int r = 0; r < 4; r++) begin
        s1_trans[r] <= mv[12+r];
        for (int c = 0; c < 3; c++) begin
          s1_prod[r][c] <= s1_prod_next[r][c];
        end
      end
      s2_cmd <= s1_cmd;
      s2_idx <= s1_idx;
      s2_val <= s1_val;
      for (int r = 0; r < 4; r++) begin
        s2_eye[r]  <= s2_eye_next[r];
        s4_clip[r] <= s4_clip_next[r];
        for (int c = 0; c < 4; c++) begin
          s3_prod[r][c] <= s3_prod_next[r][c];
        end
      end
      dv_ok[0]  <= s4_clip[3] != '0;
      dv_den[0] <= dv_den_next;
      for (int l = 0; l < 3; l++) begin
        dv_ovf[0][l] <= dv_ovf_next[l];
        dv_neg[0][l] <= dv_neg_next[l];
      end
      for (int k = 0; k <= NS; k++) begin
        for (int l = 0; l < 3; l++) begin
          dv_rem[k][l] <= dv_rem_next[k][l];
          dv_low[k][l] <= dv_low_next[k][l];
          dv_quo[k][l] <= dv_quo_next[k][l];
        end
      end
      for (int k = 1; k <= NS; k++) begin
        dv_ok[k]  <= dv_ok[k-1];
        dv_den[k] <= dv_den[k-1];
        for (int l = 0; l < 3; l++) begin
          dv_ovf[k][l] <= dv_ovf[k-1][l];
          dv_neg[k][l] <= dv_neg[k-1][l];
        end
      end
      nd_ok <= dv_ok[NS];
      for (int l = 0; l < 3; l++) begin
        nd_val[l] <= nd_val_next[l];
      end
      vp_ok     <= nd_ok;
      vp_prod_x <= vp_ax * $signed({1'b0, vp_width});
      vp_prod_y <= vp_ay * $signed({1'b0, vp_height});
      vp_depth  <= vpw_pkg::sat32({{32{vp_az[32]}}, vp_az[32:1]});
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !out_ready) begin
      skid_valid <= vp_valid;
    end else begin
      out_valid <= vp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        window_x     <= skid.x;
        window_y     <= skid.y;
        window_depth <= skid.z;
        point_ok     <= skid.ok;
      end
    end else if (out_valid && !out_ready) begin
      skid <= res;
    end else if (vp_valid) begin
      window_x     <= res.x;
      window_y     <= res.y;
      window_depth <= res.z;
      point_ok     <= res.ok;
    end
  end

  // a held skid entry always has an output transaction in front of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output valid");

  // the skid entry stays while the receiver stalls
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid)
    else $error("skid entry dropped during stall");

  // a failed projection carries zero coordinates
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_ok |-> window_x == '0 && window_y == '0 && window_depth == '0)
    else $error("failed projection with nonzero coordinates");

endmodule

`default_nettype wire

// File: bench/tb_vertex_project_to_window_unit.sv
`timescale 1ns / 100ps

module tb_vertex_project_to_window_unit;

  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 250;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  vpw_pkg::cmd_t      command;
  logic [4:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] window_x;
  logic signed [31:0] window_y;
  logic signed [31:0] window_depth;
  logic               point_ok;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_value;

  vertex_project_to_window_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .coef_index(coef_index), .coef_value(coef_value),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .window_x(window_x), .window_y(window_y), .window_depth(window_depth),
    .point_ok(point_ok),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_value(cfg_value)
  );

  // clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // predictor state
  longint             mv_mat[16];
  longint             pj_mat[16];
  logic signed [15:0] vp_left;
  logic signed [15:0] vp_bottom;
  logic [15:0]        vp_width;
  logic [15:0]        vp_height;

  vpw_pkg::win_t windows_due[$];
  int   mismatches;
  int   windows_seen;
  int   failed_w_seen;
  int   loads_sent;
  int   projects_sent;
  bit   send_quiet;
  bit   recv_quiet;
  int   hold_trigger;

  function automatic longint clamp_q(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (vpw_pkg::SAT_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one matrix times vector, each product floored to Q16.16
  function automatic void transform(input longint m[16], input longint src[4],
                                    output longint dst[4]);
    longint acc;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += (m[c*4+r] * src[c]) >>> 16;
      dst[r] = clamp_q(acc);
    end
  endfunction

  function automatic vpw_pkg::win_t project_point(logic signed [31:0] px,
                                                  logic signed [31:0] py,
                                                  logic signed [31:0] pz);
    longint obj[4];
    longint eye[4];
    longint clip[4];
    longint ndc[3];
    vpw_pkg::win_t res;
    obj[0] = longint'(px);
    obj[1] = longint'(py);
    obj[2] = longint'(pz);
    obj[3] = 65536;
    transform(mv_mat, obj, eye);
    transform(pj_mat, eye, clip);
    res = '0;
    if (clip[3] == 0) return res;
    for (int i = 0; i < 3; i++) ndc[i] = clamp_q((clip[i] * 65536) / clip[3]);
    res.x  = 32'(clamp_q((((65536 + ndc[0]) * longint'(vp_width)) >>> 1)
                         + longint'(vp_left) * 65536));
    res.y  = 32'(clamp_q((((65536 + ndc[1]) * longint'(vp_height)) >>> 1)
                         + longint'(vp_bottom) * 65536));
    res.z  = 32'(clamp_q((65536 + ndc[2]) >>> 1));
    res.ok = 1'b1;
    return res;
  endfunction

  // send one input transaction, idling at random first unless send_quiet is set
  task automatic send_item(vpw_pkg::cmd_t c, logic [4:0] idx, logic signed [31:0] cv,
                           logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] pz);
    if (!send_quiet) begin
      while ($urandom_range(0, 99) < 36) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    command    <= c;
    coef_index <= idx;
    coef_value <= cv;
    point_x    <= px;
    point_y    <= py;
    point_z    <= pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c == vpw_pkg::CMD_LOAD) begin
      if (!idx[4]) mv_mat[idx[3:0]] = longint'(cv);
      else pj_mat[idx[3:0]] = longint'(cv);
      loads_sent++;
    end else begin
      windows_due.insert(windows_due.size(), project_point(px, py, pz));
      projects_sent++;
    end
  endtask

  task automatic load_coef(logic [4:0] idx, logic signed [31:0] cv);
    send_item(vpw_pkg::CMD_LOAD, idx, cv, $urandom, $urandom, $urandom);
  endtask

  task automatic project(logic signed [31:0] px, logic signed [31:0] py,
                         logic signed [31:0] pz);
    send_item(vpw_pkg::CMD_PROJECT, 5'($urandom), $urandom, px, py, pz);
  endtask

  // let the pipeline empty before touching the viewport
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (windows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(vpw_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_value <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      vpw_pkg::REG_VP_LEFT:   vp_left   = val;
      vpw_pkg::REG_VP_BOTTOM: vp_bottom = val;
      vpw_pkg::REG_VP_WIDTH:  vp_width  = val;
      default:                vp_height = val;
    endcase
    @(posedge clk);
  endtask

  task automatic set_viewport(logic [15:0] l, logic [15:0] b, logic [15:0] w,
                              logic [15:0] h);
    drain();
    write_reg(vpw_pkg::REG_VP_LEFT, l);
    write_reg(vpw_pkg::REG_VP_BOTTOM, b);
    write_reg(vpw_pkg::REG_VP_WIDTH, w);
    write_reg(vpw_pkg::REG_VP_HEIGHT, h);
  endtask

  task automatic load_identity();
    for (int i = 0; i < 32; i++) load_coef(5'(i), (i % 16) % 5 == 0 ? 32'sh10000 : 32'sh0);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'(longint'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
      default: return 32'(longint'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'sh0;
      default: return 32'(longint'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
    endcase
  endfunction

  // all-zero matrices after reset: clip w is zero, so every result fails
  task automatic test_reset_state();
    project(32'sh10000, 32'sh20000, 32'sh30000);
    project(32'sh7fffffff, 32'sh80000000, 32'sh0);
  endtask

  // identity transform with field extremes and the full viewport range
  task automatic test_identity_extremes();
    load_identity();
    set_viewport(16'h8000, 16'h7fff, 16'hffff, 16'hffff);
    project(32'sh0, 32'sh0, 32'sh0);
    project(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    project(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    project(32'shffff0000, 32'sh10000, 32'sh8000);
    set_viewport(16'h0, 16'h0, 16'h0, 16'h0);
    project(32'sh8000, 32'shffff8000, 32'sh1);
  endtask

  // clip w forced to zero, then saturating coefficients
  task automatic test_zero_w_and_saturation();
    load_coef(31, 32'sh0);
    project(32'sh10000, 32'sh10000, 32'sh10000);
    load_coef(31, 32'sh7fffffff);
    load_coef(0, 32'sh7fffffff);
    load_coef(5, 32'sh80000000);
    project(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    load_coef(23, 32'sh0001);
    project(32'sh1, 32'shffffffff, 32'sh0);
  endtask

  task automatic random_items(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 15) load_coef(5'($urandom_range(0, 31)), rand_coef());
      else project(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // several viewport settings, each over a randomly filled pair of matrices
  task automatic test_random_phases();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_viewport(16'd0, 16'd0, 16'd640, 16'd480);
        1: set_viewport(16'h7fff, 16'h8000, 16'h0, 16'hffff);
        2: set_viewport(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        default: set_viewport(16'hff00, 16'h0040, 16'd1920, 16'd1080);
      endcase
      for (int i = 0; i < 32; i++) load_coef(5'(i), rand_coef());
      random_items(150);
    end
  endtask

  // no idling on either side for a long run of items
  task automatic test_full_rate();
    send_quiet = 1'b1;
    recv_quiet = 1'b1;
    random_items(200);
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering projections
  task automatic test_back_pressure();
    send_quiet = 1'b1;
    hold_trigger++;
    for (int k = 0; k < 80; k++) project(rand_coord(), rand_coord(), rand_coord());
    send_quiet = 1'b0;
  endtask

  // receiver: random stalls, quiet stretches and one long hold-off
  int hold_seen;
  int hold_left;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
    end else begin
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_quiet) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 36);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    vpw_pkg::win_t want;
    if (!rst && out_valid && out_ready) begin
      windows_seen++;
      if (windows_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%h y=%h z=%h ok=%b",
                                       window_x, window_y, window_depth, point_ok);
      end else begin
        want = windows_due.pop_front();
        if (!want.ok) failed_w_seen++;
        if (want.x !== window_x || want.y !== window_y || want.z !== window_depth ||
            want.ok !== point_ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h ok=%b, got x=%h y=%h z=%h ok=%b",
                     want.x, want.y, want.z, want.ok,
                     window_x, window_y, window_depth, point_ok);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout with %0d results outstanding", windows_due.size());
        $display("tb_vertex_project_to_window_unit failed");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = vpw_pkg::CMD_LOAD;
    coef_index   = '0;
    coef_value   = '0;
    point_x      = '0;
    point_y      = '0;
    point_z      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = vpw_pkg::REG_VP_LEFT;
    cfg_value    = '0;
    mismatches   = 0;
    windows_seen = 0;
    failed_w_seen = 0;
    loads_sent   = 0;
    projects_sent = 0;
    send_quiet   = 1'b0;
    recv_quiet   = 1'b0;
    hold_trigger = 0;
    for (int i = 0; i < 16; i++) begin
      mv_mat[i] = 0;
      pj_mat[i] = 0;
    end
    vp_left   = '0;
    vp_bottom = '0;
    vp_width  = '0;
    vp_height = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_identity_extremes();
    test_zero_w_and_saturation();
    test_random_phases();
    test_full_rate();
    test_back_pressure();
    drain();

    $display("covered %0d coefficient loads and %0d projections (%0d with zero clip w)",
             loads_sent, projects_sent, failed_w_seen);
    $display("viewport extremes, saturation, full-rate streaming and a long output stall");
    if (mismatches == 0 && windows_due.size() == 0) begin
      $display("tb_vertex_project_to_window_unit passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, windows_due.size());
      $display("tb_vertex_project_to_window_unit failed");
    end
    $finish;
  end

endmodule

// File: vertex_project_to_window_unit.f
rtl/vpw_pkg.sv
rtl/vertex_project_to_window_unit.sv
bench/tb_vertex_project_to_window_unit.sv
